[rtl/ray_wall_attenuation_sum_top_macros.svh]
// Assertion macros for the ray wall attenuation block.
// Used by ray_wall_attenuation_sum_top; needs nothing else.
`ifndef RAY_WALL_ATTENUATION_SUM_TOP_MACROS_SVH
`define RAY_WALL_ATTENUATION_SUM_TOP_MACROS_SVH

// same-cycle implication
`define RWAS_ASSERT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RWAS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rwas_pkg.sv]
// Shared types and constants for the ray wall attenuation block.
// No dependencies.
`timescale 1ns / 1ps

package rwas_pkg;

	localparam int COORD_W       = 10;
	localparam int SLOT_W        = 4;
	localparam int MAT_W         = 3;
	localparam int LOSS_W        = 16;
	localparam int WHOLE_W       = 8;
	localparam int WALLS_W       = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int DEF_MAX_WALLS = 16;

	localparam logic [COORD_W-1:0] RST_TX_X       = COORD_W'(750);
	localparam logic [COORD_W-1:0] RST_TX_Y       = COORD_W'(400);
	localparam logic [WALLS_W-1:0] RST_WALLS      = WALLS_W'(4);
	localparam logic [LOSS_W-1:0]  RST_LOSS_GLASS = LOSS_W'(538);
	localparam logic [LOSS_W-1:0]  RST_LOSS_IRR   = LOSS_W'(4390);
	localparam logic [LOSS_W-1:0]  RST_LOSS_CONC  = LOSS_W'(493);
	localparam logic [LOSS_W-1:0]  RST_LOSS_WOOD  = LOSS_W'(977);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	localparam logic [MAT_W-1:0] MAT_GLASS    = 3'd1;
	localparam logic [MAT_W-1:0] MAT_IRR_GLAS = 3'd2;
	localparam logic [MAT_W-1:0] MAT_CONCRETE = 3'd3;
	localparam logic [MAT_W-1:0] MAT_WOOD     = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TX_X       = 3'd0,
		REG_TX_Y       = 3'd1,
		REG_WALLS      = 3'd2,
		REG_LOSS_GLASS = 3'd3,
		REG_LOSS_IRR   = 3'd4,
		REG_LOSS_CONC  = 3'd5,
		REG_LOSS_WOOD  = 3'd6
	} rwas_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} rwas_state_t;

	typedef struct packed {
		logic               op;
		logic [SLOT_W-1:0]  wall_slot;
		logic [COORD_W-1:0] corner_x;
		logic [COORD_W-1:0] corner_y;
		logic [COORD_W-1:0] extent_x;
		logic [COORD_W-1:0] extent_y;
		logic [MAT_W-1:0]   material;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
	} rwas_in_t;

	typedef struct packed {
		logic [LOSS_W-1:0]  loss_total;
		logic [WHOLE_W-1:0] loss_whole;
		logic               saturated;
	} rwas_out_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] length;
		logic [COORD_W-1:0] width;
		logic [MAT_W-1:0]   material;
	} rwas_wall_t;

endpackage

[rtl/ray_wall_attenuation_sum_top.sv]
// Ray wall attenuation: wall table memory plus Bresenham walk with box hit test.
// Depends on rwas_pkg and ray_wall_attenuation_sum_top_macros.svh.
//
//   port group   dir   handshake            contents
//   in_*         in    in_valid/in_ready    rwas_in_t: wall load or trace start
//   out_*        out   out_valid/out_ready  rwas_out_t: loss of one trace
//   cfg_*        in    cfg_wr_en only       register index and write data
//
// A load request writes one table slot, if the slot is below MAX_WALLS. A trace
// visits P = max(dx,dy)+1 pixels, testing each of the N walls in use at every
// pixel (one wall read per cycle), then drains the read pipeline.
// Reset sets config registers to their defaults and clears control; walls stay.
// A finished result waits in the output register; the next request is taken
// meanwhile, and a trace only stalls at its end if that register is still full.
`timescale 1ns / 1ps
`include "ray_wall_attenuation_sum_top_macros.svh"

module ray_wall_attenuation_sum_top #(
	parameter int MAX_WALLS = rwas_pkg::DEF_MAX_WALLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rwas_pkg::rwas_in_t               in_req,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rwas_pkg::rwas_out_t              out_rsp,
	input  logic                             cfg_wr_en,
	input  logic [rwas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rwas_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rwas_pkg::*;

	localparam int ADDR_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int ERR_W  = COORD_W + 3;

	// config registers
	logic [COORD_W-1:0] tx_x_q, tx_y_q;
	logic [WALLS_W-1:0] walls_q;
	logic [LOSS_W-1:0]  loss_glass_q, loss_irr_q, loss_conc_q, loss_wood_q;

	// control
	rwas_state_t state_q, state_d;
	logic        issue, load_out, accept, trace_acc;

	// walk state
	logic [COORD_W-1:0]      x_q, y_q, dx_q, dy_q;
	logic                    sx_q, sy_q;
	logic signed [ERR_W-1:0] err_q;
	logic [WALLS_W-1:0]      wall_cnt_q, walls_n;

	// memory and pipeline
	rwas_wall_t         wall_mem [MAX_WALLS];
	rwas_wall_t         rd_data_s1;
	logic               vld_s1;
	logic [COORD_W-1:0] px_s1, py_s1;
	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;

	// accumulation and output
	logic [LOSS_W-1:0] sum_q, sum_nx, mat_loss;
	logic [LOSS_W:0]   sum_add;
	logic [COORD_W:0]  right_b, bottom_b;
	logic              hit;
	logic              out_valid_q;
	rwas_out_t         out_q;

	// step logic
	logic                  last_wall, at_end, step_x, step_y;
	logic signed [ERR_W:0] e2, dx_e, dy_e, err_ext, err_sum;
	logic [COORD_W-1:0]    st_dx, st_dy;

	assign accept    = in_valid && in_ready;
	assign trace_acc = accept && (in_req.op == OP_TRACE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_x_q       <= RST_TX_X;
			tx_y_q       <= RST_TX_Y;
			walls_q      <= RST_WALLS;
			loss_glass_q <= RST_LOSS_GLASS;
			loss_irr_q   <= RST_LOSS_IRR;
			loss_conc_q  <= RST_LOSS_CONC;
			loss_wood_q  <= RST_LOSS_WOOD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TX_X:       tx_x_q       <= cfg_data[COORD_W-1:0];
				REG_TX_Y:       tx_y_q       <= cfg_data[COORD_W-1:0];
				REG_WALLS:      walls_q      <= cfg_data[WALLS_W-1:0];
				REG_LOSS_GLASS: loss_glass_q <= cfg_data[LOSS_W-1:0];
				REG_LOSS_IRR:   loss_irr_q   <= cfg_data[LOSS_W-1:0];
				REG_LOSS_CONC:  loss_conc_q  <= cfg_data[LOSS_W-1:0];
				REG_LOSS_WOOD:  loss_wood_q  <= cfg_data[LOSS_W-1:0];
				default: ;
			endcase
		end
	end

	// walls beyond the table depth are not tested
	assign walls_n = (32'(walls_q) > MAX_WALLS) ? WALLS_W'(MAX_WALLS) : walls_q;

	assign last_wall = (walls_n == '0) ||
		(({1'b0, wall_cnt_q} + 1'b1) == {1'b0, walls_n});
	assign at_end = (x_q == tx_x_q) && (y_q == tx_y_q);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_req.op == OP_TRACE)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_wall && at_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!vld_s1 && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Bresenham step
	assign e2      = {err_q, 1'b0};
	assign dx_e    = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_q});
	assign dy_e    = $signed({{(ERR_W+1-COORD_W){1'b0}}, dy_q});
	assign step_x  = e2 > -dy_e;
	assign step_y  = e2 < dx_e;
	assign err_ext = {err_q[ERR_W-1], err_q};
	assign err_sum = err_ext - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

	assign st_dx = (tx_x_q > in_req.start_x) ? (tx_x_q - in_req.start_x)
		: (in_req.start_x - tx_x_q);
	assign st_dy = (tx_y_q > in_req.start_y) ? (tx_y_q - in_req.start_y)
		: (in_req.start_y - tx_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_cnt_q <= '0;
		end else if (trace_acc) begin
			wall_cnt_q <= '0;
		end else if (issue) begin
			wall_cnt_q <= last_wall ? '0 : wall_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (trace_acc) begin
			x_q   <= in_req.start_x;
			y_q   <= in_req.start_y;
			dx_q  <= st_dx;
			dy_q  <= st_dy;
			sx_q  <= in_req.start_x < tx_x_q;
			sy_q  <= in_req.start_y < tx_y_q;
			err_q <= $signed({{(ERR_W-COORD_W){1'b0}}, st_dx})
				- $signed({{(ERR_W-COORD_W){1'b0}}, st_dy});
		end else if (issue && last_wall) begin
			if (step_x)
				x_q <= sx_q ? x_q + COORD_W'(1) : x_q - COORD_W'(1);
			if (step_y)
				y_q <= sy_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
			err_q <= err_sum[ERR_W-1:0];
		end
	end

	// wall table: one write port for loads, one read port for the scan
	assign wr_en   = accept && (in_req.op == OP_LOAD) && (32'(in_req.wall_slot) < MAX_WALLS);
	assign wr_addr = ADDR_W'(in_req.wall_slot);
	assign rd_en   = issue && (walls_n != '0);
	assign rd_addr = ADDR_W'(wall_cnt_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			wall_mem[wr_addr] <= '{left: in_req.corner_x, top: in_req.corner_y,
				length: in_req.extent_x, width: in_req.extent_y,
				material: in_req.material};
		if (rd_en)
			rd_data_s1 <= wall_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= rd_en;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			px_s1 <= x_q;
			py_s1 <= y_q;
		end
	end

	// hit test, one bit wider so the far bound never wraps
	assign right_b  = {1'b0, rd_data_s1.left} + {1'b0, rd_data_s1.length};
	assign bottom_b = {1'b0, rd_data_s1.top} + {1'b0, rd_data_s1.width};
	assign hit = (px_s1 >= rd_data_s1.left) && ({1'b0, px_s1} <= right_b)
		&& (py_s1 >= rd_data_s1.top) && ({1'b0, py_s1} <= bottom_b);

	always_comb begin
		case (rd_data_s1.material)
			MAT_GLASS:    mat_loss = loss_glass_q;
			MAT_IRR_GLAS: mat_loss = loss_irr_q;
			MAT_CONCRETE: mat_loss = loss_conc_q;
			MAT_WOOD:     mat_loss = loss_wood_q;
			default:      mat_loss = '0;
		endcase
	end

	assign sum_add = {1'b0, sum_q} + {1'b0, (hit ? mat_loss : LOSS_W'(0))};
	assign sum_nx  = sum_add[LOSS_W] ? '1 : sum_add[LOSS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_q <= '0;
		else if (trace_acc)
			sum_q <= '0;
		else if (vld_s1)
			sum_q <= sum_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= '{loss_total: sum_q, loss_whole: sum_q[LOSS_W-1 -: WHOLE_W],
				saturated: (sum_q == '1)};
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	`RWAS_ASSERT(a_idle_drained, clk, arst_n, state_q == ST_IDLE, !vld_s1 && wall_cnt_q == '0, "idle with a wall read in flight")
	`RWAS_ASSERT(a_read_in_range, clk, arst_n, rd_en, wall_cnt_q < walls_n, "wall read beyond walls in use")
	`RWAS_ASSERT_NEXT(a_sum_monotone, clk, arst_n, vld_s1, sum_q >= $past(sum_q), "loss sum decreased during a trace")

endmodule
